// ===== src/wcg_pkg.sv =====
package wcg_pkg;

  localparam int unsigned MaxLength    = 4096;
  localparam int unsigned CoefFracBits = 15;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned DivW   = 12;
  localparam int unsigned PhaseW = 32;

  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages        = PhaseW / DivStepsPerStage;

  localparam int unsigned HornerSteps = 6;
  localparam int unsigned CosLat      = 3 + 3 * HornerSteps + 2;
  localparam int unsigned MetaDepth   = DivStages + 1 + CosLat;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  localparam int unsigned RndSh = 30 - CoefFracBits;

  localparam logic [30:0] Q30One    = 31'h4000_0000;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic [29:0] KHalf     = 30'd536870912;
  localparam logic [29:0] K054      = 30'd579820585;
  localparam logic [29:0] K046      = 30'd493921239;
  localparam logic [29:0] K042      = 30'd450971566;
  localparam logic [29:0] K008      = 30'd85899346;

  // taylor divisors 2k(2k-1) for k = 7 down to 2
  localparam logic [7:0] HornerDiv [HornerSteps] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

  typedef enum logic [1:0] {
    KindRect     = 2'd0,
    KindHann     = 2'd1,
    KindHamming  = 2'd2,
    KindBlackman = 2'd3
  } win_kind_e;

  typedef enum logic {
    RegKind   = 1'b0,
    RegLength = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    win_kind_e         kind;
    logic              beyond;
    logic [IdxW-1:0]   idx;
    logic [DivW-1:0]   divisor;
  } item_t;

  typedef struct packed {
    logic      vld;
    win_kind_e kind;
    logic      beyond;
  } meta_t;

endpackage

// ===== src/wcg_front.sv =====
module wcg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [wcg_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      in_vld_i,
  output logic                      in_rdy_o,
  input  logic [wcg_pkg::IdxW-1:0]  in_idx_i,
  input  logic                      full_i,
  output logic                      push_o,
  output wcg_pkg::item_t            item_o
);
  import wcg_pkg::*;

  win_kind_e       kind_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindHann;
      len_q  <= LenW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegKind:   kind_q <= win_kind_e'(cfg_wdata_i[1:0]);
        RegLength: len_q  <= cfg_wdata_i;
      endcase
    end
  end

  always_comb begin
    priority if (len_q < LenW'(2)) begin
      len_eff = LenW'(2);
    end else if (len_q > LenW'(MaxLength)) begin
      len_eff = LenW'(MaxLength);
    end else begin
      len_eff = len_q;
    end
  end

  assign in_rdy_o       = ~full_i;
  assign push_o         = in_vld_i & ~full_i;
  assign item_o.kind    = kind_q;
  assign item_o.beyond  = {1'b0, in_idx_i} >= len_eff;
  assign item_o.idx     = in_idx_i;
  assign item_o.divisor = DivW'(len_eff - LenW'(1));

endmodule

// ===== src/wcg_fifo.sv =====
module wcg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wcg_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output wcg_pkg::item_t item_o
);
  import wcg_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o = cnt_q == (QPtrW+1)'(QueueDepth);
  assign vld_o  = cnt_q != '0;
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

endmodule

// ===== src/wcg_cos.sv =====
module wcg_cos (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [wcg_pkg::PhaseW-1:0]  phase_i,
  output logic [30:0]                 mag_o,
  output logic                        neg_o
);
  import wcg_pkg::*;

  logic [30:0] rr_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic [30:0] th_q;
  logic [31:0] x2_q;
  logic [30:0] r_lo;
  logic [61:0] th_prod;
  logic [61:0] x2_prod;

  logic [30:0] ht   [HornerSteps+1];
  logic [31:0] hx2  [HornerSteps+1];
  logic        hneg [HornerSteps+1];

  // fold into a quarter turn
  assign r_lo    = {1'b0, phase_i[29:0]};
  assign th_prod = 62'(rr_q) * 62'(HalfPiQ30);
  assign x2_prod = 62'(th_q) * 62'(th_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q   <= phase_i[30] ? Q30One - r_lo : r_lo;
      neg1_q <= phase_i[31] ^ phase_i[30];
      th_q   <= th_prod[60:30];
      neg2_q <= neg1_q;
      x2_q   <= x2_prod[61:30];
      neg3_q <= neg2_q;
    end
  end

  assign ht[0]   = Q30One;
  assign hx2[0]  = x2_q;
  assign hneg[0] = neg3_q;

  for (genvar j = 0; j < HornerSteps; j++) begin : g_horner
    localparam logic [7:0]  Dv    = HornerDiv[j];
    localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(HornerDiv[j]));

    logic [31:0] na_q, nb_q, qa_q, x2a_q, x2b_q, x2c_q;
    logic        nega_q, negb_q, negc_q;
    logic [30:0] t_q;
    logic [62:0] pa;
    logic [63:0] pb;
    logic [39:0] qc;
    logic [31:0] rem;
    logic [31:0] quo;

    assign pa  = 63'(hx2[j]) * 63'(ht[j]);
    assign pb  = 64'(na_q) * 64'(Recip);
    assign qc  = 40'(qa_q) * 40'(Dv);
    assign rem = nb_q - qc[31:0];
    assign quo = qa_q + 32'(rem >= {24'b0, Dv});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        na_q   <= pa[61:30];
        x2a_q  <= hx2[j];
        nega_q <= hneg[j];
        qa_q   <= pb[63:32];
        nb_q   <= na_q;
        x2b_q  <= x2a_q;
        negb_q <= nega_q;
        t_q    <= 31'({1'b0, Q30One} - quo);
        x2c_q  <= x2b_q;
        negc_q <= negb_q;
      end
    end

    assign ht[j+1]   = t_q;
    assign hx2[j+1]  = x2c_q;
    assign hneg[j+1] = negc_q;
  end

  logic [62:0] pf;
  logic [31:0] nf_q;
  logic        negf_q;
  logic [30:0] mag_q;
  logic        nego_q;

  assign pf = 63'(hx2[HornerSteps]) * 63'(ht[HornerSteps]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nf_q   <= pf[61:30];
      negf_q <= hneg[HornerSteps];
      mag_q  <= (nf_q[31:1] >= Q30One) ? '0 : Q30One - nf_q[31:1];
      nego_q <= negf_q;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = nego_q;

endmodule

// ===== src/wcg_back.sv =====
module wcg_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_vld_i,
  input  wcg_pkg::item_t             q_item_i,
  output logic                       pop_o,
  output logic                       out_vld_o,
  input  logic                       out_rdy_i,
  output logic [wcg_pkg::CoefW-1:0]  coef_o,
  output logic                       beyond_o
);
  import wcg_pkg::*;

  logic en;
  logic out_vld_q;

  assign en    = ~out_vld_q | out_rdy_i;
  assign pop_o = q_vld_i & en;

  meta_t meta_q [MetaDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MetaDepth; i++) begin
        meta_q[i] <= '0;
      end
    end else if (en) begin
      meta_q[0] <= '{vld: pop_o, kind: q_item_i.kind, beyond: q_item_i.beyond};
      for (int i = 1; i < MetaDepth; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // long division of index * 2^32 by length - 1, one quotient nibble per stage
  logic [DivW-1:0]   rem_q [DivStages+1];
  logic [PhaseW-1:0] quo_q [DivStages+1];
  logic [DivW-1:0]   dvs_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= ({1'b0, q_item_i.idx} >= {1'b0, q_item_i.divisor}) ?
                  q_item_i.idx - q_item_i.divisor : q_item_i.idx;
      quo_q[0] <= '0;
      dvs_q[0] <= q_item_i.divisor;
    end
  end

  for (genvar s = 1; s <= DivStages; s++) begin : g_div
    logic [DivW-1:0]             r_c;
    logic [DivStepsPerStage-1:0] bits_c;

    always_comb begin
      logic [DivW:0] r2;
      r_c    = rem_q[s-1];
      bits_c = '0;
      for (int i = 0; i < DivStepsPerStage; i++) begin
        r2 = {r_c, 1'b0};
        if (r2 >= {1'b0, dvs_q[s-1]}) begin
          r_c = DivW'(r2 - {1'b0, dvs_q[s-1]});
          bits_c[DivStepsPerStage-1-i] = 1'b1;
        end else begin
          r_c = r2[DivW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s] <= r_c;
        quo_q[s] <= {quo_q[s-1][PhaseW-DivStepsPerStage-1:0], bits_c};
        dvs_q[s] <= dvs_q[s-1];
      end
    end
  end

  logic [30:0] mag1, mag2;
  logic        neg1, neg2;

  wcg_cos u_cos1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (quo_q[DivStages]),
    .mag_o   (mag1),
    .neg_o   (neg1)
  );

  wcg_cos u_cos2 (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i ({quo_q[DivStages][PhaseW-2:0], 1'b0}),
    .mag_o   (mag2),
    .neg_o   (neg2)
  );

  // scale cosine terms, rounded on magnitude
  meta_t       mt;
  logic [29:0] k1;
  logic [60:0] p1, p2;
  meta_t       meta1_q;
  logic [29:0] m1_q, m2_q;
  logic        n1_q, n2_q;

  assign mt = meta_q[MetaDepth-1];
  assign k1 = (mt.kind == KindHamming) ? K046 : KHalf;
  assign p1 = 61'(k1) * 61'(mag1) + 61'(Q30One >> 1);
  assign p2 = 61'(K008) * 61'(mag2) + 61'(Q30One >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else if (en) begin
      meta1_q <= mt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= p1[59:30];
      m2_q <= p2[59:30];
      n1_q <= neg1;
      n2_q <= neg2;
    end
  end

  logic signed [32:0] t1, t2, w;
  logic [30:0]        ws;
  logic [30:0]        wr;
  logic [CoefW-1:0]   coef_d;
  logic [CoefW-1:0]   coef_q;
  logic               beyond_q;

  assign t1 = n1_q ? 33'(m1_q) : -33'(m1_q);
  assign t2 = n2_q ? -33'(m2_q) : 33'(m2_q);

  always_comb begin
    unique case (meta1_q.kind)
      KindRect:     w = 33'(Q30One);
      KindHann:     w = 33'(KHalf) + t1;
      KindHamming:  w = 33'(K054) + t1;
      KindBlackman: w = 33'(K042) + t1 + t2;
    endcase
    priority if (w < 0) begin
      ws = '0;
    end else if (w > 33'(Q30One)) begin
      ws = Q30One;
    end else begin
      ws = w[30:0];
    end
    wr     = ws + 31'(1 << (RndSh - 1));
    coef_d = meta1_q.beyond ? '0 : CoefW'(wr >> RndSh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= meta1_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coef_q   <= coef_d;
      beyond_q <= meta1_q.beyond;
    end
  end

  assign out_vld_o = out_vld_q;
  assign coef_o    = coef_q;
  assign beyond_o  = beyond_q;

endmodule

// ===== src/window_coefficient_generator_core.sv =====
// throughput: one index per cycle, set by the fully pipelined divider and cosine units,
// while the output side is not stalled
// a four-entry queue takes index beats while the result side is stalled, until full
// reset: queue and pipeline empty, kind Hann, length 256
module window_coefficient_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [wcg_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,   // [11:0] sample_index
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [15:0] coefficient
  output logic [0:0]                m_axis_tuser    // [0] index_beyond_length
);
  import wcg_pkg::*;

  item_t f_item, q_item;
  logic  push, full, q_vld, pop;
  logic  beyond;

  wcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_vld_i    (s_axis_tvalid),
    .in_rdy_o    (s_axis_tready),
    .in_idx_i    (s_axis_tdata[IdxW-1:0]),
    .full_i      (full),
    .push_o      (push),
    .item_o      (f_item)
  );

  wcg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .item_o (q_item)
  );

  wcg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_vld_i   (q_vld),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .coef_o    (m_axis_tdata),
    .beyond_o  (beyond)
  );

  assign m_axis_tuser = beyond;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("out-of-range index beat with nonzero coefficient");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 16'(1 << CoefFracBits))
    else $error("coefficient above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

endmodule
